/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the proportional share core.
// Each macro expands to one labeled concurrent assertion reporting by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/pss_pkg.sv */
// Package for the proportional symbol share core: field widths, codes and
// the controller state type. No dependencies.
package pss_pkg;

    localparam int AMOUNT_W      = 16;
    localparam int TOTAL_W       = 22;
    localparam int PROD_W        = 2 * AMOUNT_W;
    localparam int FLOW_INDEX_W  = 6;
    localparam int MAX_FLOWS_DEF = 64;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_EREAD,
        ST_EOUT
    } state_t;

endpackage

/* hdl/pss_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on pss_pkg for the operand and product widths.
module pss_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pss_pkg::AMOUNT_W-1:0]  a,
    input  logic [pss_pkg::AMOUNT_W-1:0]  b,
    output logic                          done,
    output logic [pss_pkg::PROD_W-1:0]    product
);
    import pss_pkg::*;

    localparam int CNT_W = $clog2(AMOUNT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(AMOUNT_W - 1);

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [AMOUNT_W-1:0] mcand_reg, mcand_next;
    logic [AMOUNT_W-1:0] hi_reg, hi_next;
    logic [AMOUNT_W-1:0] lo_reg, lo_next;
    logic [AMOUNT_W:0]   partial;

    always_comb
    begin
        run_next   = run_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        partial    = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
        if (start)
        begin
            run_next   = 1'b1;
            cnt_next   = '0;
            mcand_next = a;
            hi_next    = '0;
            lo_next    = b;
        end
        else if (run_reg)
        begin
            // The upper half takes the partial sum, and the pair shifts right.
            hi_next  = partial[AMOUNT_W:1];
            lo_next  = {partial[0], lo_reg[AMOUNT_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

/* hdl/pss_div.sv */
// Restoring divider producing one quotient bit per cycle. The caller
// guarantees a quotient below 2**AMOUNT_W. Depends on pss_pkg for widths.
module pss_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pss_pkg::PROD_W-1:0]    dividend,
    input  logic [pss_pkg::TOTAL_W-1:0]   divisor,
    output logic                          done,
    output logic [pss_pkg::AMOUNT_W-1:0]  quotient
);
    import pss_pkg::*;

    localparam int CNT_W = $clog2(AMOUNT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(AMOUNT_W - 1);

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TOTAL_W-1:0]  dvsr_reg, dvsr_next;
    logic [TOTAL_W-1:0]  rem_reg, rem_next;
    logic [AMOUNT_W-1:0] lo_reg, lo_next;
    logic [TOTAL_W:0]    trial;
    logic [TOTAL_W:0]    diff;
    logic                fits;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvsr_next = dvsr_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        trial     = {rem_reg, lo_reg[AMOUNT_W-1]};
        fits      = trial >= {1'b0, dvsr_reg};
        diff      = trial - {1'b0, dvsr_reg};
        if (start)
        begin
            // The upper half is already below the divisor, so only the low
            // dividend bits still have to be brought down.
            run_next  = 1'b1;
            cnt_next  = '0;
            dvsr_next = divisor;
            rem_next  = TOTAL_W'(dividend[PROD_W-1:AMOUNT_W]);
            lo_next   = dividend[AMOUNT_W-1:0];
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
            lo_next  = {lo_reg[AMOUNT_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvsr_reg <= dvsr_next;
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
    end

    assign done     = done_reg;
    assign quotient = lo_reg;

endmodule

/* hdl/proportional_symbol_share_core.sv */
// Proportional symbol share core: a demand transfer is taken in idle, busy stays low.
// An allocation reads and grants each of its n flows (scaled: through the 16-step
// serial multiplier and 16-step serial divider), then reads out one result per flow.
// An empty allocation gives its single result in the next cycle without raising busy.
// Asynchronous active-low reset empties the frame; the demand store is not cleared.
// Depends on pss_pkg, pss_mul, pss_div and assert_macros.svh.
`include "assert_macros.svh"

module proportional_symbol_share_core #(
    parameter int MAX_FLOWS = pss_pkg::MAX_FLOWS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              func,
    input  logic [pss_pkg::AMOUNT_W-1:0]      amount,
    output logic                              done,
    output logic [pss_pkg::FLOW_INDEX_W-1:0]  flow_index,
    output logic [pss_pkg::AMOUNT_W-1:0]      granted,
    output logic [pss_pkg::AMOUNT_W-1:0]      remaining,
    output logic                              scaled,
    output logic                              no_flows,
    output logic                              dropped,
    output logic                              last
);
    import pss_pkg::*;

    localparam int IDX_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
    localparam int CNT_W = $clog2(MAX_FLOWS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FLOWS);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                ovf_reg, ovf_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [AMOUNT_W-1:0] budget_reg, budget_next;
    logic [AMOUNT_W-1:0] sum_reg, sum_next;
    logic [AMOUNT_W-1:0] grant_reg, grant_next;
    logic                scale_reg, scale_next;
    logic                drop_reg, drop_next;

    logic                    done_reg, done_next;
    logic [FLOW_INDEX_W-1:0] flow_index_reg, flow_index_next;
    logic [AMOUNT_W-1:0]     granted_reg, granted_next;
    logic [AMOUNT_W-1:0]     remaining_reg, remaining_next;
    logic                    scaled_reg, scaled_next;
    logic                    no_flows_reg, no_flows_next;
    logic                    dropped_reg, dropped_next;
    logic                    last_reg, last_next;

    logic [AMOUNT_W-1:0] store_mem [MAX_FLOWS];
    logic [AMOUNT_W-1:0] rd_data_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [AMOUNT_W-1:0] mem_wdata;

    logic                mul_start, mul_done;
    logic [PROD_W-1:0]   product;
    logic                div_start, div_done;
    logic [AMOUNT_W-1:0] quotient;
    logic                accept;
    logic                last_flow;

    pss_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (rd_data_reg),
        .b       (budget_reg),
        .done    (mul_done),
        .product (product)
    );

    pss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign last_flow = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        total_next      = total_reg;
        ovf_next        = ovf_reg;
        idx_next        = idx_reg;
        budget_next     = budget_reg;
        sum_next        = sum_reg;
        grant_next      = grant_reg;
        scale_next      = scale_reg;
        drop_next       = drop_reg;
        done_next       = 1'b0;
        flow_index_next = flow_index_reg;
        granted_next    = granted_reg;
        remaining_next  = remaining_reg;
        scaled_next     = scaled_reg;
        no_flows_next   = no_flows_reg;
        dropped_next    = dropped_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = grant_reg;
        mul_start       = 1'b0;
        div_start       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && func == FUNC_ADD)
                begin
                    if (cnt_reg < CNT_MAX)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = IDX_W'(cnt_reg);
                        mem_wdata  = amount;
                        total_next = TOTAL_W'(total_reg + TOTAL_W'(amount));
                        cnt_next   = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else if (accept)
                begin
                    budget_next = amount;
                    drop_next   = ovf_reg;
                    scale_next  = total_reg > TOTAL_W'(amount);
                    idx_next    = '0;
                    sum_next    = '0;
                    if (cnt_reg == '0)
                    begin
                        done_next       = 1'b1;
                        flow_index_next = '0;
                        granted_next    = '0;
                        remaining_next  = amount;
                        scaled_next     = 1'b0;
                        no_flows_next   = 1'b1;
                        dropped_next    = ovf_reg;
                        last_next       = 1'b1;
                        total_next      = '0;
                        ovf_next        = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (scale_reg)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
                else
                begin
                    grant_next = rd_data_reg;
                    state_next = ST_ACC;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    grant_next = quotient;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                // Grants overwrite the demands in place for the output pass.
                mem_we   = 1'b1;
                sum_next = sum_reg + grant_reg;
                if (last_flow)
                begin
                    idx_next   = '0;
                    state_next = ST_EREAD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_EREAD:
            begin
                state_next = ST_EOUT;
            end
            ST_EOUT:
            begin
                done_next       = 1'b1;
                flow_index_next = FLOW_INDEX_W'(idx_reg);
                granted_next    = rd_data_reg;
                remaining_next  = budget_reg - sum_reg;
                scaled_next     = scale_reg;
                no_flows_next   = 1'b0;
                dropped_next    = drop_reg;
                last_next       = last_flow;
                if (last_flow)
                begin
                    cnt_next   = '0;
                    total_next = '0;
                    ovf_next   = 1'b0;
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_EREAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // An empty allocation also closes the frame counter.
        if (state_reg == ST_IDLE && accept && func == FUNC_ALLOC && cnt_reg == '0)
        begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        budget_reg     <= budget_next;
        sum_reg        <= sum_next;
        grant_reg      <= grant_next;
        scale_reg      <= scale_next;
        drop_reg       <= drop_next;
        flow_index_reg <= flow_index_next;
        granted_reg    <= granted_next;
        remaining_reg  <= remaining_next;
        scaled_reg     <= scaled_next;
        no_flows_reg   <= no_flows_next;
        dropped_reg    <= dropped_next;
        last_reg       <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= store_mem[idx_reg];
    end

    assign done       = done_reg;
    assign flow_index = flow_index_reg;
    assign granted    = granted_reg;
    assign remaining  = remaining_reg;
    assign scaled     = scaled_reg;
    assign no_flows   = no_flows_reg;
    assign dropped    = dropped_reg;
    assign last       = last_reg;

    `ASSERT_IMPL(a_empty_single, clk, rst_n, done && no_flows, last && !scaled, "empty result not final")
    `ASSERT_IMPL(a_frame_busy, clk, rst_n, done && !last, busy, "idle before the final grant")
    `ASSERT_NEXT(a_empty_alloc, clk, rst_n, accept && func == FUNC_ALLOC && cnt_reg == '0, done && no_flows, "empty allocation gave no result")

endmodule
